[src/riff_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// riff_pkg
// Types, tag constants and helpers shared by the RIFF LIST/INFO deframer.
// ----------------------------------------------------------------------------
package riff_pkg;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhHeader  = 3'd1,
    PhPayload = 3'd2,
    PhPad     = 3'd3,
    PhDone    = 3'd4,
    PhError   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrShortHdr  = 2'd1,
    ErrOversize  = 2'd2,
    ErrMissPad   = 2'd3
  } err_e;

  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  // Tags as they arrive, first byte in the top bits.
  localparam logic [31:0] TagInam = 32'h494E414D;
  localparam logic [31:0] TagIart = 32'h49415254;
  localparam logic [31:0] TagIcmt = 32'h49434D54;
  localparam logic [31:0] TagIsft = 32'h49534654;

  // Bit 2 flags an unknown tag, bits 1..0 carry the string class.
  localparam logic [2:0] ClassUnknown = 3'b100;

  typedef struct packed {
    logic       string_valid;
    logic [7:0] string_byte;
    logic [1:0] string_class;
    logic       string_last;
    logic       empty_string;
    logic       list_done;
    logic [1:0] error_code;
  } result_t;

  function automatic logic [2:0] tag_class(input logic [31:0] tag);
    logic [2:0] cls;
    unique case (tag)
      TagInam: cls = 3'd0;
      TagIart: cls = 3'd1;
      TagIcmt: cls = 3'd2;
      TagIsft: cls = 3'd3;
      default: cls = ClassUnknown;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

[src/riff_info_subchunk_deframer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// riff_info_subchunk_deframer_core
// Walks a RIFF LIST/INFO payload one byte per word and emits string bytes
// of the INAM, IART, ICMT and ISFT subchunks with class and last mark.
// ----------------------------------------------------------------------------
// Each accepted word gives one result word, registered in the main or skid
// entry. Throughput: one word per cycle while the skid entry is empty; parser
// state updates at acceptance and the two-entry output register keeps input
// open while one result waits. Reset clears phase to idle and empties both.
// ----------------------------------------------------------------------------
module riff_info_subchunk_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // data_byte[7:0], list_length[39:8]
  input  wire logic        s_axis_tuser_i,  // operation[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // string_valid[0], string_byte[8:1],
                                            // empty_string[9], list_done[10],
                                            // error_code[12:11], zero[15:13]
  output logic [1:0]       m_axis_tuser_o,  // string_class[1:0]
  output logic             m_axis_tlast_o   // string_last
);

  riff_pkg::phase_e phase_q, phase_d;
  logic [31:0] list_rem_q, list_rem_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic [31:0] pay_rem_q, pay_rem_d;
  logic [2:0]  class_q, class_d;
  logic        pad_q, pad_d;
  riff_pkg::err_e err_q, err_d;

  riff_pkg::result_t res;
  riff_pkg::result_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  logic        accept, take;
  logic        op;
  logic [7:0]  b;
  logic [31:0] len;
  logic [31:0] lr_dec, pay_dec, size_new;
  logic [2:0]  hdr_cls;
  logic        hdr_last, size_over, pay_end;

  assign op  = s_axis_tuser_i;
  assign b   = s_axis_tdata_i[7:0];
  assign len = s_axis_tdata_i[39:8];

  assign s_axis_tready_o = !skid_valid_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign take   = out_valid_q && m_axis_tready_i;

  assign lr_dec    = list_rem_q - 32'd1;
  assign pay_dec   = pay_rem_q - 32'd1;
  assign pay_end   = (pay_rem_q == 32'd1);
  assign hdr_last  = (hdr_cnt_q == 3'd7);
  assign size_new  = {b, size_q[31:8]};
  // size > list_remaining - 1 is size >= list_remaining here
  assign size_over = (size_new >= list_rem_q);
  assign hdr_cls   = riff_pkg::tag_class(tag_q);

  // Next state
  always_comb begin
    logic [31:0] nxt_lr;
    logic        do_next;
    phase_d   = phase_q;
    list_rem_d = list_rem_q;
    hdr_cnt_d = hdr_cnt_q;
    tag_d     = tag_q;
    size_d    = size_q;
    pay_rem_d = pay_rem_q;
    class_d   = class_q;
    pad_d     = pad_q;
    err_d     = err_q;
    nxt_lr    = lr_dec;
    do_next   = 1'b0;
    if (op == riff_pkg::OpStart) begin
      list_rem_d = len;
      pay_rem_d  = '0;
      class_d    = '0;
      pad_d      = 1'b0;
      err_d      = riff_pkg::ErrNone;
      nxt_lr     = len;
      do_next    = 1'b1;
    end else begin
      unique case (phase_q)
        riff_pkg::PhHeader: begin
          list_rem_d = lr_dec;
          hdr_cnt_d  = hdr_cnt_q + 3'd1;
          if (!hdr_cnt_q[2]) begin
            tag_d = {tag_q[23:0], b};
          end else begin
            size_d = size_new;
          end
          if (hdr_last) begin
            if (size_over) begin
              phase_d = riff_pkg::PhError;
              err_d   = riff_pkg::ErrOversize;
            end else begin
              class_d   = hdr_cls;
              pay_rem_d = size_new;
              pad_d     = size_new[0];
              if (size_new == 32'd0) begin
                do_next = 1'b1;
              end else begin
                phase_d = riff_pkg::PhPayload;
              end
            end
          end
        end
        riff_pkg::PhPayload: begin
          list_rem_d = lr_dec;
          pay_rem_d  = pay_dec;
          if (pay_end) begin
            if (pad_q) begin
              if (lr_dec == 32'd0) begin
                phase_d = riff_pkg::PhError;
                err_d   = riff_pkg::ErrMissPad;
              end else begin
                phase_d = riff_pkg::PhPad;
              end
            end else begin
              do_next = 1'b1;
            end
          end
        end
        riff_pkg::PhPad: begin
          list_rem_d = lr_dec;
          pad_d      = 1'b0;
          do_next    = 1'b1;
        end
        default: ;  // drop bytes while idle, done or in error
      endcase
    end
    if (do_next) begin
      if (nxt_lr == 32'd0) begin
        phase_d = riff_pkg::PhDone;
      end else if (nxt_lr < 32'd8) begin
        phase_d = riff_pkg::PhError;
        err_d   = riff_pkg::ErrShortHdr;
      end else begin
        phase_d   = riff_pkg::PhHeader;
        hdr_cnt_d = '0;
        tag_d     = '0;
        size_d    = '0;
      end
    end
  end

  // Result fields
  always_comb begin
    res = '0;
    if (op == riff_pkg::OpData) begin
      if (phase_q == riff_pkg::PhPayload && !class_q[2]) begin
        res.string_valid = 1'b1;
        res.string_byte  = b;
        res.string_class = class_q[1:0];
        res.string_last  = pay_end;
      end
      if (phase_q == riff_pkg::PhHeader && hdr_last && !size_over &&
          size_new == 32'd0 && !hdr_cls[2]) begin
        res.empty_string = 1'b1;
        res.string_class = hdr_cls[1:0];
      end
    end
    res.list_done  = (phase_d == riff_pkg::PhDone);
    res.error_code = (phase_d == riff_pkg::PhError) ? err_d : riff_pkg::ErrNone;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= riff_pkg::PhIdle;
      list_rem_q <= '0;
      hdr_cnt_q  <= '0;
      tag_q      <= '0;
      size_q     <= '0;
      pay_rem_q  <= '0;
      class_q    <= '0;
      pad_q      <= 1'b0;
      err_q      <= riff_pkg::ErrNone;
    end else if (accept) begin
      phase_q    <= phase_d;
      list_rem_q <= list_rem_d;
      hdr_cnt_q  <= hdr_cnt_d;
      tag_q      <= tag_d;
      size_q     <= size_d;
      pay_rem_q  <= pay_rem_d;
      class_q    <= class_d;
      pad_q      <= pad_d;
      err_q      <= err_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.error_code, out_q.list_done, out_q.empty_string,
                            out_q.string_byte, out_q.string_valid};
  assign m_axis_tuser_o  = out_q.string_class;
  assign m_axis_tlast_o  = out_q.string_last;

  // Assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a word while output entry is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready_i))
    else $error("skid filled although output entry could drain");

  a_done_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.list_done && out_q.error_code != riff_pkg::ErrNone))
    else $error("list_done reported together with an error");

  a_hdr_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == riff_pkg::PhHeader |-> list_rem_q >= (32'd8 - {29'd0, hdr_cnt_q}))
    else $error("header phase without room for the remaining header bytes");

endmodule
`default_nettype wire
